[hw/rtl/kpl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and codes for the keypad passcode lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

  localparam int KEY_W     = 4;
  localparam int DIGIT_W   = 4;
  localparam int SHOWN     = 8;
  localparam int PASS_W    = DIGIT_W * SHOWN;
  localparam int COUNT_W   = 4;
  localparam int FAIL_W    = 3;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIGIT_W-1:0] BLANK          = 4'd15;
  localparam logic [KEY_W-1:0]   KEY_LAST_DIGIT = 4'd9;
  localparam logic [PASS_W-1:0]  PASSCODE_RST   = 32'h1111_1111;
  localparam logic [FAIL_W-1:0]  MAX_FAIL_RST   = 3'd3;

  typedef enum logic [KEY_W-1:0] {
    KEY_BACKSPACE = 4'd10,
    KEY_ENTER     = 4'd11
  } key_cmd_t;

  typedef enum logic [1:0] {
    OUT_NONE     = 2'd0,
    OUT_ACCEPTED = 2'd1,
    OUT_REJECTED = 2'd2,
    OUT_LOCKED   = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PASSCODE     = 1'd0,
    REG_MAX_FAILURES = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PASS_W-1:0] passcode;
    logic [FAIL_W-1:0] max_failures;
  } cfg_t;

  typedef struct packed {
    logic [FAIL_W-1:0]  failure_count;
    logic [PASS_W-1:0]  entry_digits;
    logic [COUNT_W-1:0] entry_count;
    outcome_t           outcome;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/kpl_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_engine
// Entry buffer, digit count and failure counter with the per-key update.
// ----------------------------------------------------------------------------
module kpl_engine import kpl_pkg::*; #(
  parameter int CODE_LENGTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [KEY_W-1:0] key,
  input  wire cfg_t             cfg,
  output result_t               res
);

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

  logic [DIGIT_W-1:0] buf_r   [CODE_LENGTH];
  logic [DIGIT_W-1:0] buf_nxt [CODE_LENGTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;

  logic               is_digit, is_bksp, is_enter;
  logic               do_add, do_del, locked, match;
  logic [CNT_W-1:0]   cnt_dec;
  logic [DIGIT_W-1:0] expect_d;
  logic [CNT_W:0]     cnt_ext;
  outcome_t           outcome;

  assign is_digit = key <= KEY_LAST_DIGIT;
  assign is_bksp  = key == KEY_BACKSPACE;
  assign is_enter = key == KEY_ENTER;
  assign do_add   = is_digit && (cnt_r < CNT_FULL);
  assign do_del   = is_bksp && (cnt_r != '0);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign locked   = fail_r >= cfg.max_failures;

  always_comb begin
    match = 1'b1;
    expect_d = BLANK;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      expect_d = (i < SHOWN) ? cfg.passcode[(i % SHOWN)*DIGIT_W +: DIGIT_W] : BLANK;
      if (buf_r[i] != expect_d) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    outcome  = OUT_NONE;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      buf_nxt[i] = buf_r[i];
      if (do_add && cnt_r == CNT_W'(i)) begin
        buf_nxt[i] = key;
      end
      if (do_del && cnt_dec == CNT_W'(i)) begin
        buf_nxt[i] = BLANK;
      end
    end
    if (do_add) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_del) begin
      cnt_nxt = cnt_dec;
    end else if (is_enter) begin
      if (locked) begin
        outcome = OUT_LOCKED;
      end else begin
        cnt_nxt = '0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
          buf_nxt[i] = BLANK;
        end
        if (match) begin
          fail_nxt = '0;
          outcome  = OUT_ACCEPTED;
        end else begin
          // below the limit here, so +1 never passes it
          fail_nxt = fail_r + FAIL_W'(1);
          outcome  = OUT_REJECTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fail_r <= '0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        buf_r[i] <= BLANK;
      end
    end else if (step_en) begin
      cnt_r  <= cnt_nxt;
      fail_r <= fail_nxt;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end
  end

  assign cnt_ext = {1'b0, cnt_nxt};

  always_comb begin
    res.outcome       = outcome;
    res.failure_count = fail_nxt;
    res.entry_count   = (cnt_ext > (CNT_W+1)'(15)) ? COUNT_W'(15)
                                                   : COUNT_W'(cnt_ext);
    for (int i = 0; i < SHOWN; i++) begin
      res.entry_digits[i*DIGIT_W +: DIGIT_W] =
        (i < CODE_LENGTH) ? buf_nxt[i % CODE_LENGTH] : BLANK;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/kpl_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_out_stage
// Result register with valid/ready toward the receiver.
// ----------------------------------------------------------------------------
module kpl_out_stage import kpl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire result_t res,
  output logic      can_load,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output result_t   out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

[hw/rtl/keypad_passcode_lock_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_passcode_lock_core
// Keypad passcode lock: one decoded key event in, one status result out.
//
// Input stream in_*: in_tdata[3:0] = key_code (0-9 digit, 10 backspace,
// 11 enter). Each request yields exactly one result on out_*.
// Output stream out_*: outcome, entry_count, entry_digits, failure_count.
// Config channel cfg_*: index 0 passcode (32 bits), index 1 max_failures
// (data[2:0]); ready whenever out of reset, write only while the block is idle.
// A request passes through the input register, then the result register,
// before its result can be taken.
// Throughput: one request per cycle while the receiver keeps out_tready high.
// When the receiver stalls the result register holds and the input
// register takes one more request; after that in_tready drops.
// Reset (rst_n low, synchronous): buffer blank, counts zero, passcode
// 0x11111111, max_failures 3, both stages empty, in_tready and cfg_ready low.
// ----------------------------------------------------------------------------
module keypad_passcode_lock_core import kpl_pkg::*; #(
  parameter int CODE_LENGTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] key_code
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [1:0] outcome, [5:2] entry_count,
                                                 // [37:6] entry_digits,
                                                 // [40:38] failure_count
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic             in_valid_r;
  logic [KEY_W-1:0] in_key_r;
  logic             advance, can_load;
  cfg_t             cfg_r;
  result_t          step_res, out_res;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passcode     <= PASSCODE_RST;
      cfg_r.max_failures <= MAX_FAIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PASSCODE:     cfg_r.passcode     <= cfg_data[PASS_W-1:0];
        REG_MAX_FAILURES: cfg_r.max_failures <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && can_load;
  assign in_tready = rst_n && (!in_valid_r || can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_key_r <= in_tdata[KEY_W-1:0];
    end
  end

  kpl_engine #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .key     (in_key_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  kpl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (step_res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0, out_res};

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_passcode_lock_core. A short table of key
// requests covers the extremes and the error outcomes. Random code attempts
// follow over several passcode and failure-limit settings. Each unpinned
// result is checked field by field against an in-bench model, with random
// idling on both streams, a long receiver hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module tb;
  import kpl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_KEYS   = 190;
  localparam int NUM_PHASES   = 7;
  localparam int IDLE_PCT     = 19;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 80;
  localparam int DIR_ROWS     = 23;

  localparam logic [KEY_W-1:0]  KEY_SPARE_LO = 4'd12;
  localparam logic [KEY_W-1:0]  KEY_SPARE_HI = 4'd15;
  localparam logic [PASS_W-1:0] ALL_BLANK    = 32'hFFFF_FFFF;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index  = REG_PASSCODE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  keypad_passcode_lock_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // directed key requests; pinned rows carry a hand-written status
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               pinned;
    outcome_t           oc;
    logic [COUNT_W-1:0] cnt;
    logic [PASS_W-1:0]  digits;
    logic [FAIL_W-1:0]  fails;
  } key_row_t;

  key_row_t dir_rows [DIR_ROWS] = '{
    '{KEY_ENTER,     1'b1, OUT_REJECTED, 4'd0, ALL_BLANK,     3'd1},
    '{KEY_BACKSPACE, 1'b1, OUT_NONE,     4'd0, ALL_BLANK,     3'd1},
    '{KEY_SPARE_LO,  1'b1, OUT_NONE,     4'd0, ALL_BLANK,     3'd1},
    '{KEY_SPARE_HI,  1'b1, OUT_NONE,     4'd0, ALL_BLANK,     3'd1},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd1,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd9,          1'b1, OUT_NONE,     4'd8, 32'h1111_1111, 3'd1},
    '{KEY_ENTER,     1'b1, OUT_ACCEPTED, 4'd0, ALL_BLANK,     3'd0},
    '{4'd0,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{4'd9,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{KEY_BACKSPACE, 1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{KEY_ENTER,     1'b1, OUT_REJECTED, 4'd0, ALL_BLANK,     3'd1},
    '{KEY_ENTER,     1'b1, OUT_REJECTED, 4'd0, ALL_BLANK,     3'd2},
    '{KEY_ENTER,     1'b1, OUT_REJECTED, 4'd0, ALL_BLANK,     3'd3},
    '{KEY_ENTER,     1'b1, OUT_LOCKED,   4'd0, ALL_BLANK,     3'd3},
    '{4'd5,          1'b0, OUT_NONE,     4'd0, 32'h0,         3'd0},
    '{KEY_ENTER,     1'b1, OUT_LOCKED,   4'd1, 32'hFFFF_FFF5, 3'd3}
  };

  // lock model state
  logic [PASS_W-1:0]  entry_nibbles = ALL_BLANK;
  logic [COUNT_W-1:0] entry_len     = '0;
  logic [FAIL_W-1:0]  fail_tally    = '0;
  logic [PASS_W-1:0]  pass_code     = PASSCODE_RST;
  logic [FAIL_W-1:0]  fail_limit    = MAX_FAIL_RST;
  int                 code_len      = 8;

  result_t pending_status [$];

  bit calm      = 1'b0;
  int hold_left = 0;
  int err_cnt   = 0;
  int n_keys    = 0;
  int n_accept  = 0;
  int n_reject  = 0;
  int n_locked  = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t lock_apply_key(logic [KEY_W-1:0] k);
    result_t r;
    r.outcome = OUT_NONE;
    if (k <= KEY_LAST_DIGIT) begin
      if (entry_len < SHOWN) begin
        entry_nibbles[DIGIT_W*entry_len +: DIGIT_W] = k;
        entry_len = entry_len + 1'b1;
      end
    end else if (k == KEY_BACKSPACE) begin
      if (entry_len != 0) begin
        entry_len = entry_len - 1'b1;
        entry_nibbles[DIGIT_W*entry_len +: DIGIT_W] = BLANK;
      end
    end else if (k == KEY_ENTER) begin
      if (fail_tally >= fail_limit) begin
        r.outcome = OUT_LOCKED;
      end else begin
        if (entry_nibbles == pass_code) begin
          r.outcome  = OUT_ACCEPTED;
          fail_tally = '0;
        end else begin
          // below the limit here, so one more never passes it
          r.outcome  = OUT_REJECTED;
          fail_tally = fail_tally + 1'b1;
        end
        entry_nibbles = ALL_BLANK;
        entry_len     = '0;
      end
    end
    r.entry_count   = entry_len;
    r.entry_digits  = entry_nibbles;
    r.failure_count = fail_tally;
    return r;
  endfunction

  // digits 0-9 then blanks only; -1 when no key sequence can match
  function automatic int enterable_len(logic [PASS_W-1:0] pc);
    int  len;
    bit  tail;
    len  = 0;
    tail = 1'b0;
    for (int i = 0; i < SHOWN; i++) begin
      if (pc[DIGIT_W*i +: DIGIT_W] == BLANK) tail = 1'b1;
      else if (tail || pc[DIGIT_W*i +: DIGIT_W] > KEY_LAST_DIGIT) return -1;
      else len++;
    end
    return len;
  endfunction

  function automatic logic [PASS_W-1:0] make_code(int len);
    logic [PASS_W-1:0] pc;
    pc = ALL_BLANK;
    for (int i = 0; i < len; i++) pc[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
    return pc;
  endfunction

  task automatic send_key(logic [KEY_W-1:0] k, bit pinned = 1'b0, result_t want = '0);
    result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-KEY_W){1'b0}}, k};
    do @(posedge clk); while (!in_tready);
    r = lock_apply_key(k);
    pending_status.push_back(pinned ? want : r);
    n_keys++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PASSCODE) pass_code = val;
    else fail_limit = val[FAIL_W-1:0];
    @(negedge clk);
  endtask

  task automatic load_setting(logic [PASS_W-1:0] pc, logic [FAIL_W-1:0] mf);
    logic [CFG_DATA_W-1:0] lim_word;
    drain();
    // upper bits of the limit word are don't-care
    lim_word = {$urandom()};
    lim_word[FAIL_W-1:0] = mf;
    write_reg(REG_PASSCODE, pc);
    write_reg(REG_MAX_FAILURES, lim_word);
    cfg_valid <= 1'b0;
    code_len = enterable_len(pc);
  endtask

  // clear leftovers, type the passcode with the odd corrected slip, enter
  task automatic enter_code();
    int n;
    n = entry_len;
    repeat (n) send_key(KEY_BACKSPACE);
    for (int i = 0; i < code_len; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_key(KEY_W'($urandom_range(0, 9)));
        send_key(KEY_BACKSPACE);
      end
      send_key(pass_code[DIGIT_W*i +: DIGIT_W]);
    end
    send_key(KEY_ENTER);
  endtask

  task automatic random_attempt();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55 && code_len >= 0) begin
      enter_code();
    end else if (pick < 72) begin
      n = $urandom_range(0, 10);
      repeat (n) send_key(KEY_W'($urandom_range(0, 9)));
      send_key(KEY_ENTER);
    end else if (pick < 82) begin
      n = $urandom_range(0, 3);
      repeat (n) send_key(KEY_W'($urandom_range(0, 9)));
      repeat (n + $urandom_range(0, 3)) send_key(KEY_BACKSPACE);
    end else begin
      repeat ($urandom_range(1, 6)) send_key(KEY_W'($urandom_range(0, 15)));
    end
  endtask

  // receiver: random stalls, calm stretches, long hold-off on demand
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_status.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("tb: unexpected status %h at cycle %0d", got, cycle_cnt);
      end else begin
        want = pending_status.pop_front();
        case (want.outcome)
          OUT_ACCEPTED: n_accept++;
          OUT_REJECTED: n_reject++;
          OUT_LOCKED:   n_locked++;
          default: ;
        endcase
        if (got.outcome !== want.outcome || got.entry_count !== want.entry_count ||
            got.entry_digits !== want.entry_digits ||
            got.failure_count !== want.failure_count) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("tb: status mismatch at cycle %0d: exp oc=%0d cnt=%0d dig=%h fail=%0d, got oc=%0d cnt=%0d dig=%h fail=%0d",
                     cycle_cnt, want.outcome, want.entry_count, want.entry_digits,
                     want.failure_count, got.outcome, got.entry_count, got.entry_digits,
                     got.failure_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: timeout with %0d statuses pending", pending_status.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    result_t want;
    int      phase_start;
    bit      mid_done;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      want.outcome       = dir_rows[i].oc;
      want.entry_count   = dir_rows[i].cnt;
      want.entry_digits  = dir_rows[i].digits;
      want.failure_count = dir_rows[i].fails;
      send_key(dir_rows[i].key, dir_rows[i].pinned, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_setting(make_code(8), 3'd7);
        1: load_setting(32'h0000_0000, 3'd1);
        2: load_setting(ALL_BLANK, 3'd7);
        3: load_setting(make_code($urandom_range(1, 7)), 3'd2);
        4: load_setting({$urandom()}, 3'd4);
        5: load_setting(make_code($urandom_range(0, 8)), 3'd7);
        default: load_setting(PASSCODE_RST, MAX_FAIL_RST);
      endcase
      calm        = (p == 2);
      phase_start = n_keys;
      mid_done    = 1'b0;
      while (n_keys - phase_start < PHASE_KEYS) begin
        random_attempt();
        if (!mid_done && n_keys - phase_start >= PHASE_KEYS / 2) begin
          mid_done = 1'b1;
          if (p == 1 || p == 4) hold_left = HOLD_CYCLES;
          if (p == 3 || p == 5) drain();
        end
      end
      // bring failures back to zero before the next setting is loaded
      if (code_len >= 0 && fail_tally < fail_limit) enter_code();
    end

    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("tb: %0d key requests over %0d settings plus reset defaults", n_keys, NUM_PHASES);
    $display("tb: %0d accepted, %0d rejected, %0d locked out, %0d mismatches",
             n_accept, n_reject, n_locked, err_cnt);
    if (err_cnt == 0 && pending_status.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
